@@ design/ulf_pkg.sv @@
// Shared types, constants and folding tables for the UTF-8 lowercase fold block.
package ulf_pkg;

  localparam int CP_W   = 21;   // widest decoded code point, four-byte form
  localparam int LEN_W  = 3;
  localparam int WORD_W = 32;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [CP_W-1:0] CP_GREEK_EXT_LO = 21'h1F00;
  localparam logic [CP_W-1:0] CP_GREEK_EXT_HI = 21'h1FFF;
  localparam logic [CP_W-1:0] CYR_UPPER_OFS   = 21'h50;
  localparam logic [CP_W-1:0] ARM_GEO_OFS     = 21'h30;
  localparam logic [CP_W-1:0] CASE_OFS        = 21'h20;

  typedef struct packed {
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;
  } ulf_item_t;

  // Native digit runs: first code point, last code point, value of the first
  localparam int NDIGIT = 16;
  localparam logic [15:0] DIGIT_LO [NDIGIT] = '{
    16'h0660, 16'h06F0, 16'h07C0, 16'h0ED0, 16'h0F20, 16'h1040, 16'h1369, 16'h17E0,
    16'h1810, 16'h19D0, 16'h1A80, 16'h1A90, 16'h1BB0, 16'h1C40, 16'h1C50, 16'h3021
  };
  localparam logic [15:0] DIGIT_HI [NDIGIT] = '{
    16'h0669, 16'h06F9, 16'h07C9, 16'h0ED9, 16'h0F29, 16'h1049, 16'h1372, 16'h17E9,
    16'h1819, 16'h19D9, 16'h1A89, 16'h1A99, 16'h1BB9, 16'h1C49, 16'h1C59, 16'h3029
  };
  localparam logic [6:0] DIGIT_BASE [NDIGIT] = '{
    7'h30, 7'h30, 7'h30, 7'h30, 7'h30, 7'h30, 7'h31, 7'h30,
    7'h30, 7'h30, 7'h30, 7'h30, 7'h30, 7'h30, 7'h30, 7'h31
  };

  // Ranges where even code points are capitals
  localparam int NEVEN = 13;
  localparam logic [15:0] EVEN_LO [NEVEN] = '{
    16'h0100, 16'h014A, 16'h01A0, 16'h0182, 16'h01DE, 16'h01F8, 16'h0222,
    16'h0246, 16'h03D8, 16'h0460, 16'h048A, 16'h04D0, 16'h1E00
  };
  localparam logic [15:0] EVEN_HI [NEVEN] = '{
    16'h0136, 16'h0176, 16'h01A4, 16'h0184, 16'h01EE, 16'h021E, 16'h0232,
    16'h024E, 16'h03FA, 16'h0480, 16'h04BE, 16'h0524, 16'h1EF8
  };

  // Ranges where odd code points are capitals
  localparam int NODD = 5;
  localparam logic [15:0] ODD_LO [NODD] = '{
    16'h0139, 16'h0179, 16'h01B3, 16'h01CD, 16'h04C1
  };
  localparam logic [15:0] ODD_HI [NODD] = '{
    16'h0147, 16'h017D, 16'h01B5, 16'h01DB, 16'h04CD
  };

  // Lone capitals whose lowercase is the next code point
  localparam int NSINGLE = 13;
  localparam logic [15:0] SINGLE_CP [NSINGLE] = '{
    16'h0187, 16'h018B, 16'h0191, 16'h0198, 16'h019D, 16'h01A7, 16'h01AC,
    16'h01AF, 16'h01B8, 16'h01BC, 16'h01F4, 16'h023B, 16'h0241
  };

  // Explicit source -> target mappings
  localparam int NFIX = 18;
  localparam logic [15:0] FIX_SRC [NFIX] = '{
    16'h0178, 16'h0181, 16'h01F6, 16'h01F7, 16'h0220, 16'h023D, 16'h0243, 16'h3007,
    16'h018E, 16'h018F, 16'h01C4, 16'h01C5, 16'h01C7, 16'h01C8, 16'h01CA, 16'h01CB,
    16'h01F1, 16'h01F2
  };
  localparam logic [15:0] FIX_DST [NFIX] = '{
    16'h00FF, 16'h0180, 16'h0195, 16'h01BF, 16'h019E, 16'h019A, 16'h0180, 16'h0030,
    16'h01DD, 16'h01DD, 16'h01C6, 16'h01C6, 16'h01C9, 16'h01C9, 16'h01CC, 16'h01CC,
    16'h01F3, 16'h01F3
  };

endpackage

@@ design/ulf_in_if.sv @@
// Input channel: four bytes at the string position.
interface ulf_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;

  modport source (output valid, output byte0, output byte1, output byte2,
                  output byte3, input ready);
  modport sink   (input valid, input byte0, input byte1, input byte2,
                  input byte3, output ready);
endinterface

@@ design/ulf_out_if.sv @@
// Result channel: folded character as UTF-8 and bytes consumed.
interface ulf_out_if ();
  logic        valid;
  logic        ready;
  logic [31:0] folded_utf8;
  logic [2:0]  bytes_consumed;

  modport source (output valid, output folded_utf8, output bytes_consumed, input ready);
  modport sink   (input valid, input folded_utf8, input bytes_consumed, output ready);
endinterface

@@ design/ulf_front.sv @@
// Front: accepts a transaction, decodes one character and applies range and digit folds.
module ulf_front
  import ulf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ulf_in_if.sink    in_chan,
  output logic      q_valid,
  input  logic      q_ready,
  output ulf_item_t q_item
);

  logic             valid_r, valid_nxt;
  ulf_item_t        item_r, item_nxt;
  logic [CP_W-1:0]  cp;
  logic [LEN_W-1:0] len;
  logic [CP_W-1:0]  folded;
  logic             up32;
  logic [15:0]      dig_ofs;

  assign in_chan.ready = !valid_r || q_ready;

  // Continuation bytes are used unchecked; 10xxxxxx leads are decoded by bits 5:3 like other leads.
  always_comb begin
    if (!in_chan.byte0[7]) begin
      cp  = {13'd0, in_chan.byte0};
      len = 3'd1;
    end else if (!in_chan.byte0[5]) begin
      cp  = {10'd0, in_chan.byte0[4:0], in_chan.byte1[5:0]};
      len = 3'd2;
    end else if (!in_chan.byte0[4]) begin
      cp  = {5'd0, in_chan.byte0[3:0], in_chan.byte1[5:0], in_chan.byte2[5:0]};
      len = 3'd3;
    end else if (!in_chan.byte0[3]) begin
      cp  = {in_chan.byte0[2:0], in_chan.byte1[5:0], in_chan.byte2[5:0],
             in_chan.byte3[5:0]};
      len = 3'd4;
    end else begin
      cp  = '0;
      len = 3'd1;
    end
  end

  always_comb begin
    dig_ofs = '0;
    up32 = (cp >= 21'h41  && cp <= 21'h5A) ||
           (cp >= 21'hC0  && cp <= 21'hDE && cp != 21'hD7) ||
           (cp >= 21'h391 && cp <= 21'h3AB) ||
           (cp >= 21'h410 && cp <= 21'h42F);
    folded = cp;
    if (up32) begin
      folded = cp + CASE_OFS;
    end else if (cp >= 21'h400 && cp <= 21'h40F) begin
      folded = cp + CYR_UPPER_OFS;
    end else if ((cp >= 21'h530 && cp <= 21'h558) || (cp >= 21'h10A0 && cp <= 21'h10C5)) begin
      folded = cp + ARM_GEO_OFS;
    end else begin
      // digit runs are disjoint, so at most one matches
      for (int i = 0; i < NDIGIT; i++) begin
        if (cp >= {5'd0, DIGIT_LO[i]} && cp <= {5'd0, DIGIT_HI[i]}) begin
          dig_ofs = cp[15:0] - DIGIT_LO[i];
          folded  = {14'd0, 7'(DIGIT_BASE[i] + {3'd0, dig_ofs[3:0]})};
        end
      end
    end
  end

  always_comb begin
    valid_nxt = in_chan.ready ? in_chan.valid : valid_r;
    item_nxt  = '{cp: folded, len: len};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_r <= item_nxt;
    end
  end

  assign q_valid = valid_r;
  assign q_item  = item_r;

endmodule

@@ design/ulf_queue.sv @@
// Two-entry queue decoupling the decode front from the fold/encode back.
module ulf_queue
  import ulf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  ulf_item_t wr_item,
  output logic      rd_valid,
  input  logic      rd_ready,
  output ulf_item_t rd_item
);

  ulf_item_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               push, pop;

  assign wr_ready = cnt_r != QCNT_W'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

@@ design/ulf_back.sv @@
// Back: Greek extended, pair, explicit and single-point folds, UTF-8 encode, output register.
module ulf_back
  import ulf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  ulf_item_t q_item,
  ulf_out_if.source out_chan
);

  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  word_r, word_nxt;
  logic [LEN_W-1:0]   len_r;
  logic [CP_W-1:0]    cp, folded;
  logic               greek_hit, pair_hit, fix_hit, single_hit;
  logic [15:0]        fix_dst;

  assign cp      = q_item.cp;
  assign q_ready = !out_valid_r || out_chan.ready;

  always_comb begin
    pair_hit   = 1'b0;
    fix_hit    = 1'b0;
    single_hit = 1'b0;
    fix_dst    = '0;
    greek_hit  = cp >= CP_GREEK_EXT_LO && cp <= CP_GREEK_EXT_HI && cp[3];
    for (int i = 0; i < NEVEN; i++) begin
      if (!cp[0] && cp >= {5'd0, EVEN_LO[i]} && cp <= {5'd0, EVEN_HI[i]}) begin
        pair_hit = 1'b1;
      end
    end
    for (int i = 0; i < NODD; i++) begin
      if (cp[0] && cp >= {5'd0, ODD_LO[i]} && cp <= {5'd0, ODD_HI[i]}) begin
        pair_hit = 1'b1;
      end
    end
    for (int i = 0; i < NFIX; i++) begin
      if (cp == {5'd0, FIX_SRC[i]}) begin
        fix_hit = 1'b1;
        fix_dst = FIX_DST[i];
      end
    end
    for (int i = 0; i < NSINGLE; i++) begin
      if (cp == {5'd0, SINGLE_CP[i]}) begin
        single_hit = 1'b1;
      end
    end
  end

  always_comb begin
    if (greek_hit) begin
      folded = cp - 21'd8;
    end else if (pair_hit) begin
      folded = cp + 21'd1;
    end else if (fix_hit) begin
      folded = {5'd0, fix_dst};
    end else if (single_hit) begin
      folded = cp + 21'd1;
    end else begin
      folded = cp;
    end
  end

  // first byte in bits 7:0
  always_comb begin
    if (folded < 21'h80) begin
      word_nxt = {25'd0, folded[6:0]};
    end else if (folded < 21'h800) begin
      word_nxt = {16'd0, 2'b10, folded[5:0], 3'b110, folded[10:6]};
    end else if (folded < 21'h10000) begin
      word_nxt = {8'd0, 2'b10, folded[5:0], 2'b10, folded[11:6], 4'b1110, folded[15:12]};
    end else begin
      word_nxt = {2'b10, folded[5:0], 2'b10, folded[11:6], 2'b10, folded[17:12],
                  5'b11110, folded[20:18]};
    end
  end

  always_comb begin
    out_valid_nxt = q_ready ? q_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      word_r <= word_nxt;
      len_r  <= q_item.len;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.folded_utf8    = word_r;
  assign out_chan.bytes_consumed = len_r;

endmodule

@@ design/utf8_lowercase_fold.sv @@
// UTF-8 lowercase fold: one character per transaction, decoded, case-folded, re-encoded.
// Path: a result passes the front register, the queue and the back output register.
// Throughput: one transaction per cycle while the output is not stalled; a 2-entry queue absorbs output stalls.
// Reset: rst_n synchronous, active low; clears valid flags, queue pointers and queue count only.
// No state carries between characters; the queue memory and data registers are not cleared.
module utf8_lowercase_fold
  import ulf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ulf_in_if.sink     in_chan,
  ulf_out_if.source  out_chan
);

  logic      fq_valid, fq_ready;
  ulf_item_t fq_item;
  logic      qb_valid, qb_ready;
  ulf_item_t qb_item;

  ulf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_item  (fq_item)
  );

  ulf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_item  (qb_item)
  );

  ulf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (qb_valid),
    .q_ready  (qb_ready),
    .q_item   (qb_item),
    .out_chan (out_chan)
  );

`ifndef SYNTHESIS
  // front holds its decoded item while the queue is full
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fq_valid && !fq_ready |=> fq_valid && $stable(fq_item))
    else $error("front item changed while stalled");

  // a single-byte encoding leaves the upper bytes zero
  a_ascii_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.folded_utf8[7] |-> out_chan.folded_utf8[31:8] == 24'd0)
    else $error("ASCII result with nonzero upper bytes");

  // lead byte of a multi-byte result is never a continuation byte
  a_lead_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.folded_utf8[7] |-> out_chan.folded_utf8[6])
    else $error("result lead byte is a continuation byte");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.bytes_consumed != 3'd0 && !out_chan.bytes_consumed[2] ||
                       out_chan.bytes_consumed == 3'd4)
    else $error("bytes consumed out of range");
`endif

endmodule
